### rtl/core/ume_pkg.sv
// shared types and constants of the memory command engine
package ume_pkg;

  // fixed word count of one small-memory block
  localparam int unsigned SMALL_WORDS = 256;

  // defaults of the top-level parameters
  localparam int unsigned SMALL_BLOCKS_DEF = 16;
  localparam int unsigned LARGE_BLOCKS_DEF = 4;
  localparam int unsigned LARGE_WORDS_DEF  = 16384;

  // op byte fields
  localparam int unsigned OP_LARGE_BIT = 7;
  localparam int unsigned OP_WRITE_BIT = 6;
  localparam int unsigned OP_WARM_BIT  = 5;
  localparam int unsigned OP_BLK_W     = 5;
  localparam int unsigned IMAGE_W      = 2;

  // input item modes
  localparam logic MODE_RX_BYTE = 1'b0;
  localparam logic MODE_TX_SLOT = 1'b1;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_WARM = 1'b1;

  // command parse phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_SIZE,
    PH_WDATA,
    PH_RDATA
  } phase_e;

  // sequencer state
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_MUL,
    ST_MOD_SUB,
    ST_MOD_FIX,
    ST_READ,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         tx_byte;
    logic [IMAGE_W-1:0] image;
    logic               last;
  } out_item_t;

endpackage

### rtl/core/ume_in_if.sv
// input channel: received bytes and transmit slots
interface ume_in_if;
  import ume_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/ume_out_if.sv
// output channel: response bytes and warmboot requests
interface ume_out_if;
  import ume_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/uart_memory_command_engine_top.sv
// top level of the memory command engine: parser, sequencer and the two stores
// Each input transfer is a received command byte or an offered transmit slot. Command bytes
// are taken one per cycle while the sequencer is idle; a write payload byte pair costs one
// RAM write on the high byte. The size byte of a large-memory command stalls input while the
// start address is reduced modulo the block size by a reciprocal multiply, a multiply-subtract
// and a final correction, each in its own state. A transmit slot during a read response
// issues the RAM read, and the read state then takes its registered data, after which the
// byte sits in the output register while the next input transfer is already taken. A result
// that finds the output register still full waits in a hold register and stalls input until
// it moves. Both stores are undefined until written; there is no clearing pass after reset.
module uart_memory_command_engine_top #(
  parameter int unsigned SMALL_BLOCKS = ume_pkg::SMALL_BLOCKS_DEF,
  parameter int unsigned LARGE_BLOCKS = ume_pkg::LARGE_BLOCKS_DEF,
  parameter int unsigned LARGE_WORDS  = ume_pkg::LARGE_WORDS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ume_in_if.sink    in_i,
  ume_out_if.source out_o
);
  import ume_pkg::*;

  localparam int unsigned SmallDepth = SMALL_BLOCKS * SMALL_WORDS;
  localparam int unsigned LargeDepth = LARGE_BLOCKS * LARGE_WORDS;
  localparam int unsigned SAW        = $clog2(SmallDepth);
  localparam int unsigned LAW        = $clog2(LargeDepth);
  localparam int unsigned RecipW     = 33 - $clog2(LARGE_WORDS);
  localparam int unsigned ProdW      = 16 + RecipW;
  localparam logic [RecipW-1:0] LargeRecip =
    RecipW'((64'd1 << 32) / 64'(LARGE_WORDS));

  // control state
  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [7:0] op_q, op_d;
  logic [15:0] waddr_q, waddr_d;
  logic [8:0] left_q, left_d;
  logic [7:0] low_q, low_d;
  logic       half_q, half_d;

  // read return info and address reduction
  logic            rd_half_q, rd_half_d;
  logic            rd_last_q, rd_last_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [16:0]     rem_q, rem_d;

  // output and hold registers
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  out_item_t res_q, res_d;

  // memory ports
  logic            small_we, small_re, large_we, large_re;
  logic [SAW-1:0]  small_addr;
  logic [LAW-1:0]  large_addr;
  logic [15:0]     wdata;
  logic [15:0]     small_rdata, large_rdata;

  logic [OP_BLK_W-1:0] blk;
  logic                is_large;
  logic                blk_valid;
  logic [12:0]         small_idx;
  logic [31:0]         large_idx;
  logic                accept;
  logic                out_free;
  logic [16:0]         waddr_inc;
  logic [15:0]         waddr_adv;
  logic [8:0]          left_dec;
  logic [31:0]         qd;
  logic [15:0]         rd_word;
  out_item_t           new_item;
  logic                new_valid;

  assign blk       = op_q[OP_BLK_W-1:0];
  assign is_large  = op_q[OP_LARGE_BIT];
  assign blk_valid = is_large ? ({1'b0, blk} < 6'(LARGE_BLOCKS))
                              : ({1'b0, blk} < 6'(SMALL_BLOCKS));

  // store indexes of the current word
  assign small_idx  = {blk, waddr_q[7:0]};
  assign small_addr = small_idx[SAW-1:0];
  assign large_idx  = 32'(blk) * 32'(LARGE_WORDS) + 32'(waddr_q);
  assign large_addr = large_idx[LAW-1:0];

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // next word address with wrap, and remaining word count
  assign waddr_inc = 17'(waddr_q) + 17'd1;
  assign waddr_adv = (is_large ? (waddr_inc >= 17'(LARGE_WORDS))
                               : (waddr_inc >= 17'(SMALL_WORDS))) ? 16'd0 : waddr_inc[15:0];
  assign left_dec  = left_q - 9'd1;

  assign qd      = 32'(prod_q[ProdW-1:32]) * 32'(LARGE_WORDS);
  assign rd_word = !blk_valid ? 16'd0 : (is_large ? large_rdata : small_rdata);

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer, parser and memory access
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    waddr_d     = waddr_q;
    left_d      = left_q;
    low_d       = low_q;
    half_d      = half_q;
    rd_half_d   = rd_half_q;
    rd_last_d   = rd_last_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    res_d       = res_q;
    small_we    = 1'b0;
    small_re    = 1'b0;
    large_we    = 1'b0;
    large_re    = 1'b0;
    wdata       = {in_i.payload.rx_byte, low_q};
    new_valid   = 1'b0;
    new_item    = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept && in_i.payload.mode == MODE_TX_SLOT) begin
          // transmit slot: fetch the word, then step the byte position
          if (phase_q == PH_RDATA) begin
            small_re  = blk_valid && !is_large;
            large_re  = blk_valid && is_large;
            rd_half_d = half_q;
            rd_last_d = half_q && (left_q == 9'd1);
            state_d   = ST_READ;
            if (half_q) begin
              half_d  = 1'b0;
              waddr_d = waddr_adv;
              left_d  = left_dec;
              if (left_dec == 9'd0) begin
                phase_d = PH_IDLE;
              end
            end else begin
              half_d = 1'b1;
            end
          end
        end else if (accept) begin
          case (phase_q)
            PH_IDLE: begin
              op_d = in_i.payload.rx_byte;
              if (in_i.payload.rx_byte[OP_WARM_BIT]) begin
                new_valid        = 1'b1;
                new_item.kind    = KIND_WARM;
                new_item.image   = in_i.payload.rx_byte[IMAGE_W-1:0];
              end else begin
                waddr_d = 16'd0;
                phase_d = in_i.payload.rx_byte[OP_LARGE_BIT] ? PH_ADDR_HI : PH_ADDR_LO;
              end
            end
            PH_ADDR_HI: begin
              waddr_d = {in_i.payload.rx_byte, 8'h00};
              phase_d = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
              waddr_d = waddr_q | 16'(in_i.payload.rx_byte);
              phase_d = PH_SIZE;
            end
            PH_SIZE: begin
              left_d  = 9'(in_i.payload.rx_byte) + 9'd1;
              half_d  = 1'b0;
              phase_d = op_q[OP_WRITE_BIT] ? PH_WDATA : PH_RDATA;
              if (is_large) begin
                state_d = ST_MOD_MUL;
              end else begin
                waddr_d = {8'h00, waddr_q[7:0]};
              end
            end
            PH_WDATA: begin
              if (!half_q) begin
                low_d  = in_i.payload.rx_byte;
                half_d = 1'b1;
              end else begin
                small_we = blk_valid && !is_large;
                large_we = blk_valid && is_large;
                half_d   = 1'b0;
                waddr_d  = waddr_adv;
                left_d   = left_dec;
                if (left_dec == 9'd0) begin
                  phase_d = PH_IDLE;
                end
              end
            end
            default: begin
              // response pending: byte dropped
            end
          endcase
        end
      end
      ST_MOD_MUL: begin
        prod_d  = ProdW'(waddr_q) * ProdW'(LargeRecip);
        state_d = ST_MOD_SUB;
      end
      ST_MOD_SUB: begin
        rem_d   = 17'(32'(waddr_q) - qd);
        state_d = ST_MOD_FIX;
      end
      ST_MOD_FIX: begin
        waddr_d = (rem_q >= 17'(LARGE_WORDS)) ? 16'(rem_q - 17'(LARGE_WORDS))
                                               : rem_q[15:0];
        state_d = ST_IDLE;
      end
      ST_READ: begin
        new_valid        = 1'b1;
        new_item.kind    = KIND_DATA;
        new_item.tx_byte = rd_half_q ? rd_word[15:8] : rd_word[7:0];
        new_item.last    = rd_last_q;
        state_d          = ST_IDLE;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a result that finds the output register full waits in the hold register
    if (new_valid && !out_free) begin
      res_d   = new_item;
      state_d = ST_HOLD;
    end
  end

  // output register loading
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_HOLD && out_free) begin
      out_valid_d = 1'b1;
      out_item_d  = res_q;
    end else if (new_valid && out_free) begin
      out_valid_d = 1'b1;
      out_item_d  = new_item;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      op_q        <= '0;
      waddr_q     <= '0;
      left_q      <= '0;
      low_q       <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      op_q        <= op_d;
      waddr_q     <= waddr_d;
      left_q      <= left_d;
      low_q       <= low_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_half_q  <= rd_half_d;
    rd_last_q  <= rd_last_d;
    prod_q     <= prod_d;
    rem_q      <= rem_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  // small and large stores
  ume_ram #(
    .WIDTH(16),
    .DEPTH(SmallDepth)
  ) u_small_ram (
    .clk_i  (clk_i),
    .we_i   (small_we),
    .re_i   (small_re),
    .addr_i (small_addr),
    .wdata_i(wdata),
    .rdata_o(small_rdata)
  );

  ume_ram #(
    .WIDTH(16),
    .DEPTH(LargeDepth)
  ) u_large_ram (
    .clk_i  (clk_i),
    .we_i   (large_we),
    .re_i   (large_re),
    .addr_i (large_addr),
    .wdata_i(wdata),
    .rdata_o(large_rdata)
  );

  // a store read is always followed by its return cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (small_re || large_re) |=> (state_q == ST_READ))
    else $error("store read not followed by return cycle");

  // a store never sees a read and a write in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((small_re || large_re) && (small_we || large_we)))
    else $error("store read and write collide");

  // the hold register is only in use while the output register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> out_valid_q)
    else $error("hold state with empty output register");

  // a response or write phase always has words left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_RDATA) || (phase_q == PH_WDATA)) |-> (left_q != 9'd0))
    else $error("data phase with no words left");

endmodule

### rtl/core/ume_ram.sv
// generic single-port ram with registered read
module ume_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
